// ===== hdl/kab_pkg.sv =====
package kab_pkg;

    localparam logic [15:0] DEFAULT_BIT_TICKS        = 16'd46;
    localparam logic [15:0] INTER_BYTE_TIMEOUT_RESET = 16'd20;
    localparam logic [15:0] COUNT_MAX                = 16'hFFFF;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic STATUS_BYTE    = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 16;

    typedef struct packed {
        logic        action;
        logic        line_level;
        logic        ms_strobe;
        logic [7:0]  byte_count;
        logic [15:0] first_timeout_ms;
        logic        auto_baud;
    } kab_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       status;
        logic [7:0] bytes_received;
        logic       last;
    } kab_result_t;

endpackage

// ===== hdl/kline_autobaud_byte_receiver_core.sv =====
// A registered result appears on the master side the cycle after the tick transaction that
// completes the byte or the timeout. Throughput: one input transaction per clock; the slave
// side stalls only while the output register is full and the master side is held off.
// Reset (rst_n, asynchronous, active low) returns the receiver to idle, sets the bit period
// to 46 ticks and the inter-byte timeout to 20 ms, and empties the output register.
module kline_autobaud_byte_receiver_core import kab_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Tick and start-request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] line_level, [1] ms_strobe, [9:2] byte_count, [25:10] first_timeout_ms,
    // [26] auto_baud, [31:27] zero
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // [0] action (0 = start request, 1 = timer tick)
    input  logic                   s_tuser,

    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] data_byte, [15:8] bytes_received
    output logic [TDATA_OUT_W-1:0] m_tdata,
    // [0] status (0 = byte, 1 = timeout)
    output logic                   m_tuser,
    output logic                   m_tlast,

    // Inter-byte timeout register write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
);

    logic [15:0] inter_byte_timeout_reg;
    logic        out_valid_reg, out_valid_next;
    kab_result_t out_res_reg;
    logic        accept;
    kab_item_t   item;
    logic        res_valid;
    kab_result_t res;

    // The register is always writable; writes are only expected while idle.
    assign cfg_ready = 1'b1;

    // The output register frees up in the same cycle that its result is taken, so a new
    // transaction can be accepted every clock while the master side keeps up.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        item.action           = s_tuser;
        item.line_level       = s_tdata[0];
        item.ms_strobe        = s_tdata[1];
        item.byte_count       = s_tdata[9:2];
        item.first_timeout_ms = s_tdata[25:10];
        item.auto_baud        = s_tdata[26];
    end

    kab_fsm u_fsm
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .accept                (accept),
        .item                  (item),
        .inter_byte_timeout_ms (inter_byte_timeout_reg),
        .res_valid             (res_valid),
        .res                   (res)
    );

    // A new result can only be loaded when the register is empty or being drained.
    assign out_valid_next = accept ? res_valid : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg          <= 1'b0;
            inter_byte_timeout_reg <= INTER_BYTE_TIMEOUT_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                inter_byte_timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.bytes_received, out_res_reg.data_byte};
    assign m_tuser  = out_res_reg.status;
    assign m_tlast  = out_res_reg.last;

    // A timeout always ends the request and carries a zero data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STATUS_TIMEOUT) |-> (m_tlast && m_tdata[7:0] == 8'd0))
        else $error("timeout result without last or with data");

    // An empty output register never holds off the slave side.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("slave side stalled with empty output register");

    // A result produced by an accepted transaction is visible on the next clock.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid) |=> m_tvalid)
        else $error("result lost between engine and output register");

endmodule

// ===== hdl/kab_fsm.sv =====
module kab_fsm import kab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  kab_item_t   item,
    input  logic [15:0] inter_byte_timeout_ms,
    output logic        res_valid,
    output kab_result_t res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_START,
        PH_HALF,
        PH_BITS,
        PH_STOP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [15:0] bit_period_reg, bit_period_next;
    logic [15:0] ms_elapsed_reg, ms_elapsed_next;
    logic [15:0] timeout_limit_reg, timeout_limit_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [7:0]  received_count_reg, received_count_next;
    logic [7:0]  wanted_count_reg, wanted_count_next;
    logic        measure_flag_reg, measure_flag_next;

    logic [15:0] tick_inc;
    logic [15:0] period_now;
    logic [16:0] half_sum;
    logic [15:0] half_period;
    logic [15:0] ms_inc;
    logic [7:0]  shift_in;
    logic [7:0]  count_inc;

    always_comb
    begin
        tick_inc    = (tick_count_reg == COUNT_MAX) ? tick_count_reg : tick_count_reg + 16'd1;
        period_now  = (bit_period_reg == 16'd0) ? 16'd1 : bit_period_reg;
        half_sum    = {1'b0, period_now} + 17'd1;
        half_period = half_sum[16:1];
        ms_inc      = (item.ms_strobe && ms_elapsed_reg != COUNT_MAX) ?
                      ms_elapsed_reg + 16'd1 : ms_elapsed_reg;
        shift_in    = {item.line_level, shift_byte_reg[7:1]};
        count_inc   = received_count_reg + 8'd1;

        phase_next          = phase_reg;
        tick_count_next     = tick_count_reg;
        bit_period_next     = bit_period_reg;
        ms_elapsed_next     = ms_elapsed_reg;
        timeout_limit_next  = timeout_limit_reg;
        bit_index_next      = bit_index_reg;
        shift_byte_next     = shift_byte_reg;
        received_count_next = received_count_reg;
        wanted_count_next   = wanted_count_reg;
        measure_flag_next   = measure_flag_reg;
        res_valid           = 1'b0;
        res                 = '0;

        if (accept)
        begin
            if (item.action == ACT_START)
            begin
                wanted_count_next   = item.byte_count;
                timeout_limit_next  = item.first_timeout_ms;
                measure_flag_next   = item.auto_baud;
                received_count_next = 8'd0;
                ms_elapsed_next     = 16'd0;
                tick_count_next     = 16'd0;
                bit_index_next      = 3'd0;
                shift_byte_next     = 8'd0;
                phase_next          = (item.byte_count == 8'd0) ? PH_IDLE : PH_WAIT;
            end
            else
            begin
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        if (item.line_level)
                        begin
                            ms_elapsed_next = ms_inc;
                            if (ms_inc > timeout_limit_reg)
                            begin
                                res_valid          = 1'b1;
                                res.data_byte      = 8'd0;
                                res.status         = STATUS_TIMEOUT;
                                res.bytes_received = received_count_reg;
                                res.last           = 1'b1;
                                phase_next         = PH_IDLE;
                            end
                        end
                        else
                        begin
                            tick_count_next = 16'd0;
                            phase_next      = PH_START;
                        end
                    end
                    PH_START:
                    begin
                        tick_count_next = tick_inc;
                        if (measure_flag_reg)
                        begin
                            if (item.line_level)
                            begin
                                bit_period_next = tick_inc;
                                tick_count_next = 16'd0;
                                phase_next      = PH_HALF;
                            end
                        end
                        else if (tick_inc >= period_now)
                        begin
                            tick_count_next = 16'd0;
                            phase_next      = PH_HALF;
                        end
                    end
                    PH_HALF:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= half_period)
                        begin
                            shift_byte_next = {item.line_level, 7'd0};
                            bit_index_next  = 3'd1;
                            tick_count_next = 16'd0;
                            phase_next      = PH_BITS;
                        end
                    end
                    PH_BITS:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= period_now)
                        begin
                            shift_byte_next = shift_in;
                            bit_index_next  = bit_index_reg + 3'd1;
                            tick_count_next = 16'd0;
                            if (bit_index_reg == 3'd7)
                            begin
                                received_count_next = count_inc;
                                res_valid           = 1'b1;
                                res.data_byte       = shift_in;
                                res.status          = STATUS_BYTE;
                                res.bytes_received  = count_inc;
                                res.last            = (count_inc >= wanted_count_reg);
                                phase_next          = (count_inc >= wanted_count_reg) ?
                                                      PH_IDLE : PH_STOP;
                            end
                        end
                    end
                    PH_STOP:
                    begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= period_now)
                        begin
                            tick_count_next    = 16'd0;
                            ms_elapsed_next    = 16'd0;
                            timeout_limit_next = inter_byte_timeout_ms;
                            phase_next         = PH_WAIT;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            tick_count_reg     <= 16'd0;
            bit_period_reg     <= DEFAULT_BIT_TICKS;
            ms_elapsed_reg     <= 16'd0;
            timeout_limit_reg  <= 16'd0;
            bit_index_reg      <= 3'd0;
            shift_byte_reg     <= 8'd0;
            received_count_reg <= 8'd0;
            wanted_count_reg   <= 8'd0;
            measure_flag_reg   <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            tick_count_reg     <= tick_count_next;
            bit_period_reg     <= bit_period_next;
            ms_elapsed_reg     <= ms_elapsed_next;
            timeout_limit_reg  <= timeout_limit_next;
            bit_index_reg      <= bit_index_next;
            shift_byte_reg     <= shift_byte_next;
            received_count_reg <= received_count_next;
            wanted_count_reg   <= wanted_count_next;
            measure_flag_reg   <= measure_flag_next;
        end
    end

    // The bit index is back at zero whenever the half-bit phase is entered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALF) |-> (bit_index_reg == 3'd0))
        else $error("bit index not cleared before the first data bit");

    // A byte result always matches the incremented received count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == STATUS_BYTE) |-> (res.bytes_received == count_inc))
        else $error("byte result count out of step");

    // A measured period is never shorter than one tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_period_reg != 16'd0)
        else $error("bit period collapsed to zero");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the K-line autobaud byte receiver.
// A short table of directed transactions comes first. Random receive requests follow, each
// with a bit-accurate line waveform, in three idling regimes. Every accepted result is
// compared with the oldest prediction of a behavioural copy of the receiver.
module tb_top;
    import kab_pkg::*;

    // Receiver sequencing, mirrored from the block's documented behaviour.
    typedef enum logic [2:0] {
        RX_IDLE,
        RX_WAIT_START,
        RX_START_BIT,
        RX_HALF_BIT,
        RX_DATA_BITS,
        RX_STOP_BIT
    } rx_phase_t;

    // One row of the directed table. Rows with typed set carry a result worked out by hand.
    typedef struct {
        kab_item_t   item;
        bit          typed;
        kab_result_t res;
    } dir_row_t;

    localparam int STALL_LIMIT = 3000; // cycles with no transaction on any channel
    localparam int HOLD_CYCLES = 300;  // long hold-off of the result side
    localparam int DRAIN_GAP   = 4;    // result register latency plus margin

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [15:0]            cfg_data  = '0;

    // Behavioural copy of the receiver state; the initial values are the reset values.
    rx_phase_t   rx_phase    = RX_IDLE;
    logic [15:0] rx_ticks    = '0;
    logic [15:0] rx_period   = DEFAULT_BIT_TICKS;
    logic [15:0] rx_ms       = '0;
    logic [15:0] rx_limit    = '0;
    logic [2:0]  rx_bit_idx  = '0;
    logic [7:0]  rx_shift    = '0;
    logic [7:0]  rx_got      = '0;
    logic [7:0]  rx_want     = '0;
    logic        rx_autobaud = 1'b0;
    logic [15:0] rx_gap_ms   = INTER_BYTE_TIMEOUT_RESET;

    kab_result_t rx_results_due[$];
    dir_row_t    dir_tab[$];

    int mismatches   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int snd_idle_pct = 26;
    int rcv_idle_pct = 58;
    int quiet_cycles = 0;
    int hold_count   = 0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;

    kline_autobaud_byte_receiver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatches++;
    endtask

    // Advances the behavioural receiver by one accepted transaction. A start request resets
    // the request state; a tick moves the bit-level sequence on by one sample.
    task automatic decode_item(input kab_item_t it, output bit emits, output kab_result_t r);
        logic [16:0] per;
        bit          eighth;
        emits = 1'b0;
        r = '0;
        eighth = 1'b0;
        per = (rx_period == 16'd0) ? 17'd1 : {1'b0, rx_period};
        if (it.action == ACT_START)
        begin
            rx_want     = it.byte_count;
            rx_limit    = it.first_timeout_ms;
            rx_autobaud = it.auto_baud;
            rx_got      = '0;
            rx_ms       = '0;
            rx_ticks    = '0;
            rx_bit_idx  = '0;
            rx_shift    = '0;
            rx_phase    = (it.byte_count == 8'd0) ? RX_IDLE : RX_WAIT_START;
        end
        else
        begin
            // The tick counter runs in every phase that times a bit, and saturates.
            if (rx_phase != RX_IDLE && rx_phase != RX_WAIT_START && rx_ticks != COUNT_MAX)
                rx_ticks++;
            case (rx_phase)
                RX_WAIT_START:
                begin
                    if (it.line_level)
                    begin
                        if (it.ms_strobe && rx_ms != COUNT_MAX)
                            rx_ms++;
                        if (rx_ms > rx_limit)
                        begin
                            emits            = 1'b1;
                            r.data_byte      = 8'h00;
                            r.status         = STATUS_TIMEOUT;
                            r.bytes_received = rx_got;
                            r.last           = 1'b1;
                            rx_phase         = RX_IDLE;
                        end
                    end
                    else
                    begin
                        rx_ticks = '0;
                        rx_phase = RX_START_BIT;
                    end
                end
                RX_START_BIT:
                begin
                    if (rx_autobaud)
                    begin
                        // The first high sample closes the start bit and fixes the period.
                        if (it.line_level)
                        begin
                            rx_period = rx_ticks;
                            rx_ticks  = '0;
                            rx_phase  = RX_HALF_BIT;
                        end
                    end
                    else if ({1'b0, rx_ticks} >= per)
                    begin
                        rx_ticks = '0;
                        rx_phase = RX_HALF_BIT;
                    end
                end
                RX_HALF_BIT, RX_DATA_BITS:
                begin
                    if ((rx_phase == RX_HALF_BIT && {1'b0, rx_ticks} >= ((per + 17'd1) >> 1)) ||
                        (rx_phase == RX_DATA_BITS && {1'b0, rx_ticks} >= per))
                    begin
                        if (rx_phase == RX_HALF_BIT)
                        begin
                            rx_bit_idx = '0;
                            rx_shift   = '0;
                        end
                        rx_shift   = {it.line_level, rx_shift[7:1]};
                        eighth     = (rx_bit_idx == 3'd7);
                        rx_bit_idx = rx_bit_idx + 3'd1;
                        rx_ticks   = '0;
                        rx_phase   = RX_DATA_BITS;
                        if (eighth)
                        begin
                            rx_got           = rx_got + 8'd1;
                            emits            = 1'b1;
                            r.data_byte      = rx_shift;
                            r.status         = STATUS_BYTE;
                            r.bytes_received = rx_got;
                            r.last           = (rx_got >= rx_want);
                            rx_phase         = r.last ? RX_IDLE : RX_STOP_BIT;
                        end
                    end
                end
                RX_STOP_BIT:
                begin
                    // One bit period into the stop bit the next start bit is awaited, now
                    // with the inter-byte limit.
                    if ({1'b0, rx_ticks} >= per)
                    begin
                        rx_ticks = '0;
                        rx_ms    = '0;
                        rx_limit = rx_gap_ms;
                        rx_phase = RX_WAIT_START;
                    end
                end
                default:
                    rx_phase = RX_IDLE;
            endcase
        end
    endtask

    function automatic kab_item_t tick_item(input logic lvl, input logic stb);
        kab_item_t it;
        // The request fields are ignored on a tick; they are filled at random all the same.
        it.action           = ACT_TICK;
        it.line_level       = lvl;
        it.ms_strobe        = stb;
        it.byte_count       = 8'($urandom);
        it.first_timeout_ms = 16'($urandom);
        it.auto_baud        = 1'($urandom);
        return it;
    endfunction

    function automatic kab_item_t start_req(input logic [7:0] cnt, input logic [15:0] tmo,
                                            input logic ab);
        kab_item_t it;
        it.action           = ACT_START;
        it.line_level       = 1'($urandom);
        it.ms_strobe        = 1'($urandom);
        it.byte_count       = cnt;
        it.first_timeout_ms = tmo;
        it.auto_baud        = ab;
        return it;
    endfunction

    task automatic add_row(input kab_item_t it, input bit typed = 1'b0,
                           input kab_result_t res = '0);
        dir_row_t row;
        row.item  = it;
        row.typed = typed;
        row.res   = res;
        dir_tab.push_back(row);
    endtask

    // Offers one transaction on the slave side, with random gaps before it, and records the
    // prediction once it has been taken. A typed result must agree with the prediction and
    // is the one that is then awaited.
    task automatic send_item(input kab_item_t it, input bit typed, input kab_result_t res);
        bit          emits;
        kab_result_t r;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it.auto_baud, it.first_timeout_ms, it.byte_count,
                     it.ms_strobe, it.line_level};
        s_tuser  <= it.action;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        decode_item(it, emits, r);
        if (typed)
        begin
            if (!emits || r !== res)
                report_mismatch($sformatf("directed row at item %0d disagrees with prediction",
                                          items_sent));
            rx_results_due.push_back(res);
        end
        else if (emits)
            rx_results_due.push_back(r);
    endtask

    task automatic send_tick(input logic lvl, input logic stb);
        send_item(tick_item(lvl, stb), 1'b0, '0);
    endtask

    // Stops offering, waits until every predicted result has been taken and then lets the
    // result register latency pass, so that the receiver is quiet for a register write.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (rx_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_gap_timeout(input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        rx_gap_ms = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One receive request: a start request, then up to four bytes drawn as a line waveform
    // of one start bit, eight data bits and a stop bit, with idle ticks between them. When
    // fewer bytes are drawn than requested, the next start request cuts the request short.
    task automatic run_request();
        int unsigned want;
        int unsigned nbytes;
        int unsigned bper;
        int unsigned pick;
        logic [15:0] tmo;
        logic [7:0]  data;
        logic [9:0]  frame;
        logic        ab;
        pick = $urandom_range(99);
        if (pick < 4)
            want = 0;
        else if (pick < 12)
            want = $urandom_range(255, 5);
        else
            want = $urandom_range(4, 1);
        pick = $urandom_range(99);
        if (pick < 10)
            tmo = 16'd0;
        else if (pick < 15)
            tmo = 16'hFFFF;
        else if (pick < 25)
            tmo = 16'($urandom);
        else
            tmo = 16'($urandom_range(12, 1));
        ab = ($urandom_range(99) < 70);
        // A fixed rate reuses the last measured period; keep slow fixed-rate bytes rare.
        if (!ab && rx_period > 16'd8 && $urandom_range(9) != 0)
            ab = 1'b1;
        send_item(start_req(8'(want), tmo, ab), 1'b0, '0);
        if (want == 0)
        begin
            repeat ($urandom_range(3, 1)) send_tick(1'($urandom), 1'($urandom));
            return;
        end
        nbytes = (want <= 4) ? want : $urandom_range(4, 1);
        repeat (nbytes)
        begin
            if (ab)
                bper = ($urandom_range(99) < 4) ? $urandom_range(48, 1) : $urandom_range(6, 2);
            else
                bper = (rx_period == 16'd0) ? 1 : int'(rx_period);
            repeat ($urandom_range(5, 0))
            begin
                send_tick(1'b1, ($urandom_range(3) == 0));
                if (rx_phase == RX_IDLE)
                    return;
            end
            data = 8'($urandom);
            // A clean period measurement wants a high first data bit.
            if (ab && $urandom_range(3) != 0)
                data[0] = 1'b1;
            frame = {1'b1, data, 1'b0};
            for (int b = 0; b < 10; b++)
                repeat (bper)
                    send_tick(frame[b] ^ ($urandom_range(199) == 0), 1'($urandom));
        end
        repeat ($urandom_range(4, 0)) send_tick(1'b1, ($urandom_range(3) == 0));
        // Occasionally a burst of arbitrary transactions, stray start requests among them.
        if ($urandom_range(99) < 8)
            repeat ($urandom_range(8, 1))
            begin
                kab_item_t it;
                it = tick_item(1'($urandom), 1'($urandom));
                if ($urandom_range(99) < 15)
                    it.action = ACT_START;
                send_item(it, 1'b0, '0);
            end
    endtask

    // Result side: random hold-off at the falling edge, and once a long hold-off counted
    // here so that the result register fills and the slave side stalls.
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            m_tready <= 1'b0;
            if (hold_count == HOLD_CYCLES)
                hold_done <= 1'b1;
            else
                hold_count <= hold_count + 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Each result transaction is checked against the oldest prediction, field by field.
    always @(posedge clk)
    begin : result_check
        kab_result_t got;
        kab_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.data_byte      = m_tdata[7:0];
            got.bytes_received = m_tdata[15:8];
            got.status         = m_tuser;
            got.last           = m_tlast;
            results_seen++;
            if (rx_results_due.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                          results_seen));
            else
            begin
                want = rx_results_due.pop_front();
                if (got.data_byte !== want.data_byte)
                    report_mismatch($sformatf("result %0d data_byte %h, predicted %h",
                                              results_seen, got.data_byte, want.data_byte));
                if (got.status !== want.status)
                    report_mismatch($sformatf("result %0d status flag %b, predicted %b",
                                              results_seen, got.status, want.status));
                if (got.bytes_received !== want.bytes_received)
                    report_mismatch($sformatf("result %0d bytes_received %0d, predicted %0d",
                                              results_seen, got.bytes_received,
                                              want.bytes_received));
                if (got.last !== want.last)
                    report_mismatch($sformatf("result %0d tlast %b, predicted %b",
                                              results_seen, got.last, want.last));
            end
        end
    end

    // Watchdog: ends the run when no channel has moved a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, rx_results_due.size());
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int phase_end;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The largest inter-byte limit first; the directed rows never reach an inter-byte
        // wait that runs out.
        write_gap_timeout(16'hFFFF);

        // A first timeout of 0 ms: the first strobed high tick ends the request.
        add_row(start_req(8'd1, 16'd0, 1'b0));
        add_row(tick_item(1'b1, 1'b1), 1'b1, {8'h00, STATUS_TIMEOUT, 8'd0, 1'b1});
        // A zero byte count ends at once, so the tick that follows meets an idle receiver.
        add_row(start_req(8'd0, 16'hFFFF, 1'b1));
        add_row(tick_item(1'b1, 1'b1));
        // The widest request with autobaud: a one-tick start bit gives a period of one tick,
        // and nine high ticks end the start bit and carry an all-ones byte.
        add_row(start_req(8'd255, 16'hFFFF, 1'b1));
        add_row(tick_item(1'b0, 1'b0));
        for (int k = 0; k < 9; k++)
            add_row(tick_item(1'b1, 1'(k)), (k == 8), {8'hFF, STATUS_BYTE, 8'd1, 1'b0});
        // A start request while busy drops the running one; at a fixed rate of one tick an
        // all-zeros byte then ends the new one-byte request.
        add_row(start_req(8'd1, 16'd0, 1'b0));
        add_row(tick_item(1'b0, 1'b1));
        for (int k = 0; k < 9; k++)
            add_row(tick_item(1'b0, 1'(k)), (k == 8), {8'h00, STATUS_BYTE, 8'd1, 1'b1});

        foreach (dir_tab[i])
            send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);

        // First regime: the sender idles now and then, the receiver often. An inter-byte
        // limit of zero makes every strobed idle tick between bytes a timeout.
        settle();
        write_gap_timeout(16'd0);
        phase_end = items_sent + 550;
        while (items_sent < phase_end)
            run_request();

        // Second regime: the other way round.
        settle();
        write_gap_timeout(16'($urandom_range(30, 1)));
        snd_idle_pct = 58;
        rcv_idle_pct = 26;
        phase_end = items_sent + 550;
        while (items_sent < phase_end)
            run_request();

        // Third regime: no idling, opened by one long hold-off of the result side.
        settle();
        write_gap_timeout(16'($urandom_range(20, 2)));
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req = 1'b1;
        phase_end = items_sent + 550;
        while (items_sent < phase_end)
            run_request();

        settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/kab_pkg.sv
hdl/kab_fsm.sv
hdl/kline_autobaud_byte_receiver_core.sv
tb/tb_top.sv
